// ===== hw/rtl/s2mpc_pkg.sv =====
package s2mpc_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int MAX_COLUMNS = 128;
  localparam int STORE_DEPTH = 128;
  localparam int ROW_LIMIT   = 128;
  localparam int COL_LIMIT   = (MAX_COLUMNS < STORE_DEPTH) ? MAX_COLUMNS : STORE_DEPTH;
  localparam int POS_W       = 7;
  localparam int TOTAL_W     = 8;
  localparam int COUNT_W     = 15;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic REG_ROW_TOTAL    = 1'b0;
  localparam logic REG_COLUMN_TOTAL = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] pixel_t;
  typedef logic [POS_W-1:0]             pos_t;
  typedef logic [TOTAL_W-1:0]           total_t;
  typedef logic [COUNT_W-1:0]           count_t;

  typedef struct packed {
    total_t rows;
    total_t cols;
    logic   restart;
  } cfg_t;

endpackage

// ===== hw/rtl/s2mpc_in_if.sv =====
interface s2mpc_in_if;
  import s2mpc_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

// ===== hw/rtl/s2mpc_out_if.sv =====
interface s2mpc_out_if;
  import s2mpc_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t window_max;
  pos_t   window_row;
  pos_t   window_col;
  logic   is_final;
  pixel_t overall_max;
  count_t overall_count;

  modport source (
    output valid, output window_max, output window_row, output window_col,
    output is_final, output overall_max, output overall_count, input ready
  );
  modport sink (
    input valid, input window_max, input window_row, input window_col,
    input is_final, input overall_max, input overall_count, output ready
  );
endinterface

// ===== hw/rtl/s2mpc_ram.sv =====
module s2mpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/s2mpc_cfg.sv =====
module s2mpc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [s2mpc_pkg::PADDR_W-1:0]   paddr,
  input  logic [s2mpc_pkg::PDATA_W-1:0]   pwdata,
  output logic [s2mpc_pkg::PDATA_W-1:0]   prdata,
  output s2mpc_pkg::cfg_t                 cfg
);
  import s2mpc_pkg::*;

  total_t row_total;
  total_t column_total;
  logic   wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_total    <= TOTAL_W'(2);
      column_total <= TOTAL_W'(2);
    end else if (wr) begin
      case (paddr[2])
        REG_ROW_TOTAL:    row_total    <= pwdata[TOTAL_W-1:0];
        REG_COLUMN_TOTAL: column_total <= pwdata[TOTAL_W-1:0];
        default:          row_total    <= row_total;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_TOTAL:    prdata = PDATA_W'(row_total);
      REG_COLUMN_TOTAL: prdata = PDATA_W'(column_total);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (row_total < TOTAL_W'(2)) begin
      cfg.rows = TOTAL_W'(2);
    end else if (row_total > TOTAL_W'(ROW_LIMIT)) begin
      cfg.rows = TOTAL_W'(ROW_LIMIT);
    end else begin
      cfg.rows = row_total;
    end
    if (column_total < TOTAL_W'(2)) begin
      cfg.cols = TOTAL_W'(2);
    end else if (column_total > TOTAL_W'(COL_LIMIT)) begin
      cfg.cols = TOTAL_W'(COL_LIMIT);
    end else begin
      cfg.cols = column_total;
    end
    cfg.restart = wr;
  end

endmodule

// ===== hw/rtl/s2mpc_core.sv =====
module s2mpc_core (
  input  logic               clk,
  input  logic               rst,
  input  s2mpc_pkg::cfg_t    cfg,
  s2mpc_in_if.sink           pixel_in,
  s2mpc_out_if.source        result_out
);
  import s2mpc_pkg::*;

  pos_t   current_row;
  pos_t   current_col;
  pos_t   row_next;
  pos_t   col_next;
  pixel_t left_pixel;
  pixel_t upper_left_pixel;
  pixel_t running_max;
  count_t running_count;
  pixel_t max_next;
  count_t count_next;
  pixel_t above;
  pixel_t cur;
  pixel_t top_max;
  pixel_t bottom_max;
  pixel_t win_max;
  logic   accept;
  logic   first;
  logic   final_pos;
  logic   produce;
  logic   out_valid;
  logic [TOTAL_W-1:0] col_inc;

  assign cur    = pixel_in.pixel_value;
  assign accept = pixel_in.valid && pixel_in.ready;
  assign pixel_in.ready = !out_valid || result_out.ready;

  s2mpc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (accept),
    .waddr (current_col[ADDR_W-1:0]),
    .wdata (cur),
    .raddr (col_next[ADDR_W-1:0]),
    .rdata (above)
  );

  assign first     = (current_row == '0) && (current_col == '0);
  assign final_pos = ({1'b0, current_row} >= cfg.rows - TOTAL_W'(1)) &&
                     ({1'b0, current_col} >= cfg.cols - TOTAL_W'(1));
  assign produce   = (current_row != '0) && (current_col != '0);
  assign col_inc   = {1'b0, current_col} + TOTAL_W'(1);

  assign top_max    = (above > upper_left_pixel) ? above : upper_left_pixel;
  assign bottom_max = (cur > left_pixel) ? cur : left_pixel;
  assign win_max    = (bottom_max > top_max) ? bottom_max : top_max;

  always_comb begin
    max_next   = running_max;
    count_next = running_count;
    if (first || (cur > running_max)) begin
      max_next   = cur;
      count_next = COUNT_W'(1);
    end else if ((cur == running_max) && (running_count != '1)) begin
      count_next = running_count + COUNT_W'(1);
    end
  end

  always_comb begin
    row_next = current_row;
    col_next = current_col;
    if (cfg.restart) begin
      row_next = '0;
      col_next = '0;
    end else if (accept) begin
      if (final_pos) begin
        row_next = '0;
        col_next = '0;
      end else if (col_inc >= cfg.cols) begin
        row_next = current_row + POS_W'(1);
        col_next = '0;
      end else begin
        col_next = col_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
      current_col <= '0;
      out_valid   <= 1'b0;
    end else begin
      current_row <= row_next;
      current_col <= col_next;
      if (accept && produce) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_pixel       <= cur;
      upper_left_pixel <= above;
      running_max      <= max_next;
      running_count    <= count_next;
    end
    if (accept && produce) begin
      result_out.window_max    <= win_max;
      result_out.window_row    <= current_row - POS_W'(1);
      result_out.window_col    <= current_col - POS_W'(1);
      result_out.is_final      <= final_pos;
      result_out.overall_max   <= final_pos ? max_next : '0;
      result_out.overall_count <= final_pos ? count_next : '0;
    end
  end

  assign result_out.valid = out_valid;

endmodule

// ===== hw/rtl/sliding_2x2_max_with_peak_count.sv =====
// A result word is registered and presented in the cycle after the pixel that completes its window.
// Throughput: one pixel word per cycle while the result register is empty or result_out.ready drains it.
// Each pixel enters while the previous result waits, as long as the result register drains.
// Reset: position, result valid and both totals (to 2) are cleared; the line store is not.
// Writing either total restarts the matrix at row 0, column 0.
module sliding_2x2_max_with_peak_count (
  input  logic                            clk,
  input  logic                            rst,
  s2mpc_in_if.sink                        pixel_in,
  s2mpc_out_if.source                     result_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [s2mpc_pkg::PADDR_W-1:0]   paddr,
  input  logic [s2mpc_pkg::PDATA_W-1:0]   pwdata,
  output logic [s2mpc_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import s2mpc_pkg::*;

  cfg_t cfg;

  assign pready = 1'b1;

  s2mpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  s2mpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel_in   (pixel_in),
    .result_out (result_out)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import s2mpc_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    pixel_t window_max;
    pos_t   window_row;
    pos_t   window_col;
    logic   is_final;
    pixel_t overall_max;
    count_t overall_count;
  } window_word_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  s2mpc_in_if  pixel_in ();
  s2mpc_out_if result_out ();

  sliding_2x2_max_with_peak_count dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pixel_in),
    .result_out (result_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  window_word_t pending_windows[$];

  total_t      row_total_q;
  total_t      column_total_q;
  pixel_t      line_mem[STORE_DEPTH];
  pixel_t      left_q;
  pixel_t      upper_left_q;
  int unsigned at_row;
  int unsigned at_col;
  pixel_t      peak;
  count_t      peak_hits;

  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned hold_cycles;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic int unsigned clamp_total(input total_t v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned matrix_cells();
    return clamp_total(row_total_q, ROW_LIMIT) * clamp_total(column_total_q, COL_LIMIT);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pixel_t random_pixel();
    case ($urandom_range(0, 7))
      0: return pixel_t'(-32768);
      1: return pixel_t'(32767);
      2: return pixel_t'(int'($urandom_range(0, 4)) - 2);
      default: return pixel_t'($urandom);
    endcase
  endfunction

  task automatic restart_matrix();
    at_row = 0;
    at_col = 0;
    peak = '0;
    peak_hits = '0;
  endtask

  task automatic predict_window(input pixel_t v);
    int unsigned rows;
    int unsigned cols;
    pixel_t above;
    pixel_t biggest;
    logic first;
    logic last;
    window_word_t w;
    rows = clamp_total(row_total_q, ROW_LIMIT);
    cols = clamp_total(column_total_q, COL_LIMIT);
    above = line_mem[at_col];
    first = (at_row == 0) && (at_col == 0);
    last = (at_row >= rows - 1) && (at_col >= cols - 1);
    if (first || v > peak) begin
      peak = v;
      peak_hits = 1;
    end else if (v == peak && peak_hits < 15'h7FFF) begin
      peak_hits++;
    end
    if (at_row >= 1 && at_col >= 1) begin
      biggest = upper_left_q;
      if (above > biggest) biggest = above;
      if (left_q > biggest) biggest = left_q;
      if (v > biggest) biggest = v;
      w.window_max = biggest;
      w.window_row = pos_t'(at_row - 1);
      w.window_col = pos_t'(at_col - 1);
      w.is_final = last;
      w.overall_max = last ? peak : '0;
      w.overall_count = last ? peak_hits : '0;
      pending_windows.push_back(w);
    end
    upper_left_q = above;
    left_q = v;
    line_mem[at_col] = v;
    if (last) begin
      at_row = 0;
      at_col = 0;
    end else if (at_col + 1 >= cols) begin
      at_col = 0;
      at_row = (at_row + 1) & 127;
    end else begin
      at_col++;
    end
  endtask

  task automatic report_word(input string what, input window_word_t want,
                             input window_word_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s: expected max %0d row %0d col %0d final %0b peak %0d count %0d",
               what, want.window_max, want.window_row, want.window_col, want.is_final,
               want.overall_max, want.overall_count);
      $display("%s: actual   max %0d row %0d col %0d final %0b peak %0d count %0d",
               what, got.window_max, got.window_row, got.window_col, got.is_final,
               got.overall_max, got.overall_count);
    end
  endtask

  task automatic check_window();
    window_word_t got;
    window_word_t want;
    got.window_max = result_out.window_max;
    got.window_row = result_out.window_row;
    got.window_col = result_out.window_col;
    got.is_final = result_out.is_final;
    got.overall_max = result_out.overall_max;
    got.overall_count = result_out.overall_count;
    if (pending_windows.size() == 0) begin
      report_word("unexpected window word", '0, got);
    end else begin
      want = pending_windows.pop_front();
      if (got.window_max !== want.window_max || got.window_row !== want.window_row ||
          got.window_col !== want.window_col || got.is_final !== want.is_final ||
          got.overall_max !== want.overall_max ||
          got.overall_count !== want.overall_count) begin
        report_word("window word mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) check_window();
  end

  initial begin
    int unsigned stall_left;
    int unsigned g;
    stall_left = 0;
    result_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        result_out.ready <= 1'b0;
        stall_left--;
      end else if (hold_cycles > 0) begin
        result_out.ready <= 1'b0;
        hold_cycles--;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          result_out.ready <= 1'b0;
          stall_left = g - 1;
        end else begin
          result_out.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_pixel(input pixel_t v);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      pixel_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_in.valid <= 1'b1;
    pixel_in.pixel_value <= v;
    do @(posedge clk); while (!pixel_in.ready);
    predict_window(v);
    items_sent++;
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    pixel_in.valid <= 1'b0;
    while (pending_windows.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input logic which, input total_t value);
    settle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == REG_ROW_TOTAL) row_total_q = value;
    else column_total_q = value;
    restart_matrix();
  endtask

  task automatic set_size(input total_t rows, input total_t cols);
    if ($urandom_range(0, 1) == 0) begin
      write_total(REG_ROW_TOTAL, rows);
      write_total(REG_COLUMN_TOTAL, cols);
    end else begin
      write_total(REG_COLUMN_TOTAL, cols);
      write_total(REG_ROW_TOTAL, rows);
    end
  endtask

  task automatic send_matrix(input int unsigned count, input int unsigned style);
    pixel_t base;
    base = random_pixel();
    for (int unsigned i = 0; i < count; i++) begin
      if (style == 0) send_pixel(random_pixel());
      else if (style == 1) send_pixel(base);
      else send_pixel(pixel_t'(base + int'($urandom_range(0, 3))));
    end
  endtask

  task automatic test_reset_defaults();
    send_pixel(pixel_t'(-32768));
    send_pixel(pixel_t'(32767));
    send_pixel(pixel_t'(0));
    send_pixel(pixel_t'(-1));
    repeat (4) send_pixel(pixel_t'(-32768));
    send_pixel(pixel_t'(5));
    send_pixel(pixel_t'(7));
    send_pixel(pixel_t'(7));
    send_pixel(pixel_t'(3));
    settle();
  endtask

  task automatic test_clamp_low();
    set_size(8'd0, 8'd1);
    send_matrix(4, 0);
    settle();
  endtask

  task automatic test_restart_mid_matrix();
    set_size(8'd3, 8'd3);
    send_matrix(5, 0);
    settle();
    write_total(REG_COLUMN_TOTAL, 8'd3);
    send_matrix(9, 2);
    settle();
  endtask

  task automatic test_output_hold();
    set_size(8'd4, 8'd6);
    calm = 1'b1;
    hold_cycles = 150;
    send_matrix(48, 0);
    settle();
    calm = 1'b0;
  endtask

  task automatic test_largest_matrix();
    set_size(8'd2, 8'd200);
    calm = 1'b1;
    send_matrix(matrix_cells(), 1);
    settle();
    set_size(8'd255, 8'd2);
    send_matrix(matrix_cells(), 1);
    settle();
    calm = 1'b0;
  endtask

  task automatic test_random_matrices();
    int unsigned start;
    int unsigned cells;
    int unsigned n_mat;
    total_t odd;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          set_size(total_t'($urandom_range(2, 8)), total_t'($urandom_range(2, 8)));
        end
        6: begin
          if ($urandom_range(0, 1) == 0)
            set_size(total_t'($urandom_range(2, 3)), total_t'($urandom_range(64, 128)));
          else
            set_size(total_t'($urandom_range(64, 128)), total_t'($urandom_range(2, 3)));
        end
        7: begin
          odd = ($urandom_range(0, 1) == 0) ? total_t'($urandom_range(129, 255))
                                            : total_t'($urandom_range(0, 1));
          if ($urandom_range(0, 1) == 0) set_size(odd, total_t'($urandom_range(0, 4)));
          else set_size(total_t'($urandom_range(0, 4)), odd);
        end
        8: begin
          write_total(logic'($urandom_range(0, 1)), total_t'($urandom_range(2, 4)));
        end
        default: begin
        end
      endcase
      cells = matrix_cells();
      n_mat = (cells > 64) ? 1 : $urandom_range(1, 3);
      repeat (n_mat) send_matrix(cells, $urandom_range(0, 2));
      if ($urandom_range(0, 5) == 0) send_matrix($urandom_range(1, cells - 1), 0);
      settle();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pixel_in.valid <= 1'b0;
    pixel_in.pixel_value <= '0;
    row_total_q = 8'd2;
    column_total_q = 8'd2;
    foreach (line_mem[i]) line_mem[i] = '0;
    left_q = '0;
    upper_left_q = '0;
    restart_matrix();
    items_sent = 0;
    mismatches = 0;
    hold_cycles = 0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_clamp_low();
    test_restart_mid_matrix();
    test_output_hold();
    test_largest_matrix();
    test_random_matrices();

    settle();
    if (pending_windows.size() != 0) begin
      mismatches += pending_windows.size();
      $display("%0d window words never arrived", pending_windows.size());
    end
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
